// File: rtl/core/vdrk_pkg.sv
`default_nettype none
package vdrk_pkg;

  localparam int ACC_W  = 48;
  localparam int KEY_W  = 46;
  localparam int NORM_W = 24;
  localparam int GNORM_W = 22;
  localparam int FRAC_W = 30;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] ONE_Q30 = KEY_W'(64'sd1 <<< FRAC_W);
  localparam logic signed [KEY_W-1:0] TWO_Q30 = KEY_W'(64'sd1 <<< (FRAC_W + 1));
  localparam logic signed [KEY_W-1:0] KEY_LIMIT = KEY_W'(64'sd1 <<< 44);

  localparam logic [2:0] ADDR_METRIC = 3'd0;

  localparam logic [1:0] METRIC_L2     = 2'd0;
  localparam logic [1:0] METRIC_INNER  = 2'd1;
  localparam logic [1:0] METRIC_COSINE = 2'd2;

  typedef struct packed {
    logic               start;
    logic               given;
    logic [GNORM_W-1:0] gna;
    logic [GNORM_W-1:0] gnb;
  } cos_req_t;

endpackage
`default_nettype wire

// File: rtl/core/vdrk_mac.sv
`default_nettype none
module vdrk_mac #(
  parameter int MAX_DIM    = 4096,
  parameter int ELEM_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic                                clear,
  input  wire logic signed [ELEM_WIDTH-1:0]        a,
  input  wire logic signed [ELEM_WIDTH-1:0]        b,
  output logic                                     done,
  output logic signed [vdrk_pkg::ACC_W-1:0]        dot_sum,
  output logic signed [vdrk_pkg::ACC_W-1:0]        diff_square_sum,
  output logic signed [vdrk_pkg::ACC_W-1:0]        norm_a_square_sum,
  output logic signed [vdrk_pkg::ACC_W-1:0]        norm_b_square_sum
);

  localparam int OW = ELEM_WIDTH + 1;
  localparam int PW = 2 * OW;
  localparam int WW = (PW > vdrk_pkg::ACC_W) ? PW : vdrk_pkg::ACC_W;
  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int AW = vdrk_pkg::ACC_W;

  logic [CW-1:0]        element_count;
  logic [1:0]           step;
  logic [1:0]           pstep;
  logic                 run;
  logic                 en;
  logic                 pv;
  logic                 fin;
  logic signed [PW-1:0] prod;
  logic signed [OW-1:0] ax, bx, dx, opx, opy;
  logic signed [WW-1:0] pe;
  logic signed [AW-1:0] term, acc_sel, acc_new;
  logic signed [AW:0]   sum;

  assign ax = OW'(a);
  assign bx = OW'(b);
  assign dx = ax - bx;

  always_comb begin
    case (step)
      2'd0: begin opx = ax; opy = bx; end
      2'd1: begin opx = dx; opy = dx; end
      2'd2: begin opx = ax; opy = ax; end
      default: begin opx = bx; opy = bx; end
    endcase
  end

  always_comb begin
    case (pstep)
      2'd0: acc_sel = dot_sum;
      2'd1: acc_sel = diff_square_sum;
      2'd2: acc_sel = norm_a_square_sum;
      default: acc_sel = norm_b_square_sum;
    endcase
  end

  // clamp the term, add, clamp the sum
  always_comb begin
    pe = WW'(prod);
    if (pe > WW'(vdrk_pkg::ACC_MAX)) term = vdrk_pkg::ACC_MAX;
    else if (pe < WW'(vdrk_pkg::ACC_MIN)) term = vdrk_pkg::ACC_MIN;
    else term = AW'(pe);
    sum = (AW+1)'(acc_sel) + (AW+1)'(term);
    if (sum > (AW+1)'(vdrk_pkg::ACC_MAX)) acc_new = vdrk_pkg::ACC_MAX;
    else if (sum < (AW+1)'(vdrk_pkg::ACC_MIN)) acc_new = vdrk_pkg::ACC_MIN;
    else acc_new = AW'(sum);
  end

  always_ff @(posedge clk) begin
    prod  <= opx * opy;
    pstep <= step;
    if (rst) begin
      run <= 1'b0; step <= 2'd0; en <= 1'b0; pv <= 1'b0; fin <= 1'b0; done <= 1'b0;
      element_count <= '0;
      dot_sum <= '0; diff_square_sum <= '0;
      norm_a_square_sum <= '0; norm_b_square_sum <= '0;
    end else begin
      pv   <= run & en;
      fin  <= run && (step == 2'd3);
      done <= fin;
      if (start) begin
        run  <= 1'b1;
        step <= 2'd0;
        en   <= (element_count < CW'(MAX_DIM));
        if (element_count < CW'(MAX_DIM)) element_count <= element_count + 1'b1;
      end else if (run) begin
        step <= step + 2'd1;
        if (step == 2'd3) run <= 1'b0;
      end
      if (pv) begin
        case (pstep)
          2'd0: dot_sum <= acc_new;
          2'd1: diff_square_sum <= acc_new;
          2'd2: norm_a_square_sum <= acc_new;
          default: norm_b_square_sum <= acc_new;
        endcase
      end
      if (clear) begin
        element_count <= '0;
        dot_sum <= '0; diff_square_sum <= '0;
        norm_a_square_sum <= '0; norm_b_square_sum <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= CW'(MAX_DIM)) else $error("element count beyond limit");
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !run) else $error("done while still running");
  a_norm_nonneg: assert property (@(posedge clk) disable iff (rst)
    !norm_a_square_sum[AW-1] && !norm_b_square_sum[AW-1]) else $error("negative norm sum");

endmodule
`default_nettype wire

// File: rtl/core/vdrk_cos.sv
`default_nettype none
module vdrk_cos (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire vdrk_pkg::cos_req_t                 req,
  input  wire logic signed [vdrk_pkg::ACC_W-1:0]  dot,
  input  wire logic signed [vdrk_pkg::ACC_W-1:0]  nsa,
  input  wire logic signed [vdrk_pkg::ACC_W-1:0]  nsb,
  output logic                                    busy,
  output logic                                    done,
  output logic signed [vdrk_pkg::KEY_W-1:0]       key
);

  localparam int AW = vdrk_pkg::ACC_W;
  localparam int NW = vdrk_pkg::NORM_W;

  typedef enum logic [2:0] {C_IDLE, C_ROOT, C_MUL, C_CHK, C_DIV, C_FIN} cstate_t;

  cstate_t              st;
  logic [4:0]           cnt;
  logic                 phase_b;
  logic [AW-1:0]        rv, root, bitv, nsb_hold, den, mag, rem;
  logic [NW-1:0]        na, nb;
  logic [2*NW-1:0]      nprod;
  logic                 neg;
  logic [vdrk_pkg::FRAC_W-1:0] q;
  logic [AW-1:0]        trial;
  logic [AW:0]          rs;

  assign trial = root + bitv;
  assign rs    = {rem, 1'b0};
  assign busy  = (st != C_IDLE);
  assign nprod = na * nb;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= C_IDLE; done <= 1'b0; cnt <= '0; phase_b <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        C_IDLE: begin
          if (req.start) begin
            neg <= dot[AW-1];
            mag <= dot[AW-1] ? AW'(-dot) : AW'(dot);
            if (req.given) begin
              na <= NW'(req.gna);
              nb <= NW'(req.gnb);
              st <= C_MUL;
            end else begin
              rv <= AW'(nsa); nsb_hold <= AW'(nsb);
              root <= '0; bitv <= AW'(64'd1 << 46);
              cnt <= '0; phase_b <= 1'b0;
              st <= C_ROOT;
            end
          end
        end
        C_ROOT: begin
          if (rv >= trial) begin
            rv   <= rv - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd23) begin
            // final root bit resolved here
            if (!phase_b) begin
              na <= NW'(rv >= trial ? (root >> 1) + bitv : root >> 1);
              rv <= nsb_hold; root <= '0; bitv <= AW'(64'd1 << 46);
              cnt <= '0; phase_b <= 1'b1;
            end else begin
              nb <= NW'(rv >= trial ? (root >> 1) + bitv : root >> 1);
              st <= C_MUL;
            end
          end
        end
        C_MUL: begin
          den <= nprod;
          st  <= C_CHK;
        end
        C_CHK: begin
          rem <= mag; q <= '0; cnt <= '0;
          if (den == '0) begin
            key <= vdrk_pkg::ONE_Q30; st <= C_FIN;
          end else if (mag >= den) begin
            key <= neg ? vdrk_pkg::TWO_Q30 : '0; st <= C_FIN;
          end else begin
            st <= C_DIV;
          end
        end
        C_DIV: begin
          if (rs >= (AW+1)'(den)) begin
            rem <= AW'(rs - (AW+1)'(den));
            q   <= {q[vdrk_pkg::FRAC_W-2:0], 1'b1};
          end else begin
            rem <= AW'(rs);
            q   <= {q[vdrk_pkg::FRAC_W-2:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(vdrk_pkg::FRAC_W - 1)) st <= C_FIN;
        end
        C_FIN: begin
          if (q != '0 || den != '0) begin
            if (!(den == '0) && mag < den)
              key <= neg ? vdrk_pkg::ONE_Q30 + vdrk_pkg::KEY_W'(q)
                         : vdrk_pkg::ONE_Q30 - vdrk_pkg::KEY_W'(q);
          end
          done <= 1'b1;
          st   <= C_IDLE;
        end
        default: st <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/vector_distance_rank_key.sv
`default_nettype none
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid / in_ready       elem_a elem_b last_elem norms_given
//                                                given_norm_a given_norm_b
// out       source     out_valid / out_ready     rank_key
// cfg       APB        psel penable pwrite       paddr pwdata prdata (metric_mode)
//
// Each word runs four products through one shared multiplier, then a
// pipelined saturating add. On the last word, cosine computes both roots in
// turn in one shift-subtract root unit (unless norms are given), then runs
// a 30-bit shift-subtract divide.
// Synchronous reset clears accumulators, count and metric to zero.
// A finished key waits in the output register; a further vector may run
// meanwhile but holds its own key until that register empties.
module vector_distance_rank_key #(
  parameter int MAX_DIM    = 4096,
  parameter int ELEM_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [ELEM_WIDTH-1:0]         elem_a,
  input  wire logic signed [ELEM_WIDTH-1:0]         elem_b,
  input  wire logic                                 last_elem,
  input  wire logic                                 norms_given,
  input  wire logic [vdrk_pkg::GNORM_W-1:0]         given_norm_a,
  input  wire logic [vdrk_pkg::GNORM_W-1:0]         given_norm_b,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [vdrk_pkg::KEY_W-1:0]         rank_key,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [2:0]                           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  localparam int AW = vdrk_pkg::ACC_W;
  localparam int KW = vdrk_pkg::KEY_W;

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_COS, S_OUT} state_t;

  state_t                    state;
  logic [1:0]                metric_mode;
  logic signed [ELEM_WIDTH-1:0] a_r, b_r;
  logic                      last_r, given_r;
  logic [vdrk_pkg::GNORM_W-1:0] gna_r, gnb_r;
  logic                      mac_clear, mac_done;
  logic signed [AW-1:0]      dot_s, diff_s, nsa_s, nsb_s;
  vdrk_pkg::cos_req_t        cos_req;
  logic                      cos_busy, cos_done;
  logic signed [KW-1:0]      cos_key, key_r, lin_key;
  logic signed [AW:0]        lin_raw;

  assign pready    = 1'b1;
  assign prdata    = {30'd0, metric_mode};
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    case (metric_mode)
      vdrk_pkg::METRIC_L2:    lin_raw = (AW+1)'(diff_s);
      vdrk_pkg::METRIC_INNER: lin_raw = -((AW+1)'(dot_s));
      default:                lin_raw = '0;
    endcase
    if (lin_raw > (AW+1)'(vdrk_pkg::KEY_LIMIT)) lin_key = vdrk_pkg::KEY_LIMIT;
    else if (lin_raw < -((AW+1)'(vdrk_pkg::KEY_LIMIT))) lin_key = -vdrk_pkg::KEY_LIMIT;
    else lin_key = KW'(lin_raw);
  end

  logic start_q;
  logic clear_q;
  assign mac_clear = clear_q;

  always_comb begin
    cos_req.start = (state == S_MAC) && mac_done && last_r
                    && (metric_mode == vdrk_pkg::METRIC_COSINE);
    cos_req.given = given_r;
    cos_req.gna   = gna_r;
    cos_req.gnb   = gnb_r;
  end

  vdrk_mac #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_mac (
    .clk(clk), .rst(rst), .start(start_q), .clear(mac_clear),
    .a(a_r), .b(b_r), .done(mac_done),
    .dot_sum(dot_s), .diff_square_sum(diff_s),
    .norm_a_square_sum(nsa_s), .norm_b_square_sum(nsb_s)
  );

  vdrk_cos u_cos (
    .clk(clk), .rst(rst), .req(cos_req), .dot(dot_s), .nsa(nsa_s), .nsb(nsb_s),
    .busy(cos_busy), .done(cos_done), .key(cos_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; metric_mode <= vdrk_pkg::METRIC_L2;
      out_valid <= 1'b0; start_q <= 1'b0; clear_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      clear_q <= 1'b0;
      if (psel && penable && pwrite && (paddr == vdrk_pkg::ADDR_METRIC))
        metric_mode <= pwdata[1:0];
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_r <= elem_a; b_r <= elem_b; last_r <= last_elem;
            given_r <= norms_given; gna_r <= given_norm_a; gnb_r <= given_norm_b;
            start_q <= 1'b1;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (mac_done) begin
            if (!last_r) state <= S_IDLE;
            else if (metric_mode == vdrk_pkg::METRIC_COSINE) state <= S_COS;
            else begin
              key_r <= lin_key;
              state <= S_OUT;
            end
          end
        end
        S_COS: begin
          if (cos_done) begin
            key_r <= cos_key;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            rank_key  <= key_r;
            out_valid <= 1'b1;
            clear_q   <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready right after a word");
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rank_key <= vdrk_pkg::KEY_LIMIT) && (rank_key >= -vdrk_pkg::KEY_LIMIT))
    else $error("key out of range");
  a_cos_start_idle: assert property (@(posedge clk) disable iff (rst)
    cos_req.start |-> !cos_busy) else $error("cosine unit restarted while busy");

endmodule
`default_nettype wire

// File: verif/tb.sv
module tb;

  localparam longint ACC_HI = (64'sd1 <<< 47) - 1;
  localparam longint ACC_LO = -(64'sd1 <<< 47);
  localparam longint ONE_K = 64'sd1 <<< 30;
  localparam longint LIM_K = 64'sd1 <<< 44;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int MAX_DIM = 4096;

  class rank_key_board;
    longint dot_acc, diff_acc, na_acc, nb_acc;
    int count;
    logic [1:0] metric;
    logic signed [vdrk_pkg::KEY_W-1:0] pending[$];
    int errors;
    int keys_seen;

    function new();
      metric = vdrk_pkg::METRIC_L2;
      errors = 0;
      keys_seen = 0;
      clear();
    endfunction

    function void clear();
      dot_acc = 0; diff_acc = 0; na_acc = 0; nb_acc = 0; count = 0;
    endfunction

    function longint clamp(longint v);
      if (v > ACC_HI) return ACC_HI;
      if (v < ACC_LO) return ACC_LO;
      return v;
    endfunction

    function longint sat_sum(longint acc, longint term);
      return clamp(clamp(acc) + clamp(term));
    endfunction

    function longint root(longint v);
      longint r, bt;
      r = 0;
      bt = 64'sd1 <<< 62;
      while (bt > v) bt = bt >>> 2;
      while (bt != 0) begin
        if (v >= r + bt) begin
          v = v - (r + bt);
          r = (r >>> 1) + bt;
        end else begin
          r = r >>> 1;
        end
        bt = bt >>> 2;
      end
      return r;
    endfunction

    function longint cos_key(longint d, longint na, longint nb);
      longint den, mag, rem, q;
      den = na * nb;
      q = 0;
      if (den == 0) return ONE_K;
      mag = d < 0 ? -d : d;
      if (mag >= den) return d < 0 ? 2 * ONE_K : 0;
      rem = mag;
      for (int i = 0; i < 30; i++) begin
        rem = rem <<< 1;
        q = q <<< 1;
        if (rem >= den) begin
          rem = rem - den;
          q = q | 1;
        end
      end
      return d < 0 ? ONE_K + q : ONE_K - q;
    endfunction

    function void note_word(logic signed [15:0] ea, logic signed [15:0] eb, logic lst,
                            logic gv, logic [21:0] gna, logic [21:0] gnb);
      longint a, b, dd, k;
      a = ea;
      b = eb;
      if (count < MAX_DIM) begin
        dot_acc = sat_sum(dot_acc, a * b);
        dd = (a - b) < 0 ? b - a : a - b;
        diff_acc = sat_sum(diff_acc, dd > (64'sd1 <<< 24) ? ACC_HI : clamp(dd * dd));
        na_acc = sat_sum(na_acc, a * a);
        nb_acc = sat_sum(nb_acc, b * b);
        count++;
      end
      if (!lst) return;
      case (metric)
        vdrk_pkg::METRIC_L2: k = diff_acc;
        vdrk_pkg::METRIC_INNER: k = -dot_acc;
        vdrk_pkg::METRIC_COSINE: k = gv ? cos_key(dot_acc, gna, gnb)
                                        : cos_key(dot_acc, root(na_acc), root(nb_acc));
        default: k = 0;
      endcase
      if (k > LIM_K) k = LIM_K;
      if (k < -LIM_K) k = -LIM_K;
      pending.push_back(k[vdrk_pkg::KEY_W-1:0]);
      clear();
    endfunction

    function void check_key(logic signed [vdrk_pkg::KEY_W-1:0] got);
      logic signed [vdrk_pkg::KEY_W-1:0] want;
      keys_seen++;
      if (pending.size() == 0) begin
        $error("rank_key: unexpected word %0d", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("rank_key: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic signed [15:0] elem_a = 0, elem_b = 0;
  logic last_elem = 0, norms_given = 0;
  logic [vdrk_pkg::GNORM_W-1:0] given_norm_a = 0, given_norm_b = 0;
  logic out_valid, out_ready = 0;
  logic signed [vdrk_pkg::KEY_W-1:0] rank_key;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  logic pready;
  longint cycles = 0;
  int stall_mode = 0;
  int words_sent = 0;
  rank_key_board board = new();

  vector_distance_rank_key uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall pattern, switched by the stimulus phase
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else case (stall_mode)
      0: out_ready <= 1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ((cycles % 13) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_key(rank_key);
  end

  task automatic write_metric(logic [1:0] m);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= vdrk_pkg::ADDR_METRIC;
    pwdata <= {30'b0, m};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.metric = m;
  endtask

  task automatic send_word(logic signed [15:0] a, logic signed [15:0] b, logic lst,
                           logic gv, logic [21:0] gna, logic [21:0] gnb);
    in_valid <= 1; elem_a <= a; elem_b <= b; last_elem <= lst;
    norms_given <= gv; given_norm_a <= gna; given_norm_b <= gnb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_word(a, b, lst, gv, gna, gnb);
    words_sent++;
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // drop valid first so the last word is not taken twice
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_vectors(int n_words);
    int left, len;
    logic gv;
    left = n_words;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if (len > left) len = left;
      gv = 1'($urandom_range(0, 1));
      for (int i = 0; i < len; i++)
        send_word(pick_elem(), pick_elem(), i == len - 1, gv,
                  ($urandom_range(0, 7) == 0) ? 22'h3fffff : 22'($urandom),
                  ($urandom_range(0, 7) == 0) ? 22'd0 : 22'($urandom));
      left -= len;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, each metric, the cosine corner cases
    for (int m = 0; m < 4; m++) begin
      write_metric(m[1:0]);
      send_word(16'sh8000, 16'sh8000, 1'b1, 1'b0, 22'd0, 22'd0);
      send_word(16'sh8000, 16'sh7fff, 1'b1, 1'b0, 22'd0, 22'd0);
      send_word(16'sh7fff, 16'sh8000, 1'b0, 1'b0, 22'd0, 22'd0);
      send_word(16'sh4000, 16'sh2000, 1'b1, 1'b1, 22'h3fffff, 22'h3fffff);
      send_word(16'sh0000, 16'sh0000, 1'b1, 1'b0, 22'd0, 22'd0);
      send_word(16'sh1234, 16'shedcc, 1'b1, 1'b1, 22'd0, 22'd5);
      drain();
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_metric(2'($urandom_range(0, 3)));
      stall_mode = ph % 3;
      random_vectors(45);
      drain();
    end
    write_metric(vdrk_pkg::METRIC_COSINE);
    random_vectors(30);
    drain();

    $display("Sent %0d element words over all four metric settings; %0d keys compared.",
             words_sent, board.keys_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
